// ----- rtl/rgbyp_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbyp_pkg
// Shared constants and types for the RGB to Y'PbPr converter.
// ----------------------------------------------------------------------------
package rgbyp_pkg;

    localparam int CFG_BITS         = 16;
    localparam int MAX_SAMPLE_RESET = 255;
    localparam int COEF_SCALE       = 1000000;
    localparam int FRAC_SHIFT       = 16;
    localparam int QUOT_BITS        = 17;
    localparam int LUMA_BITS        = 17;
    localparam int DIFF_BITS        = 16;
    localparam int LUMA_MAX         = 65536;
    localparam int DIFF_POS_MAX     = 32767;
    localparam int DIFF_NEG_MAX     = 32768;
    localparam int LANES            = 3;

    // luma, blue difference, red difference; each row is red, green, blue
    localparam int COEF [9] = '{
        299000,  587000,  114000,
        -168736, -331264, 500000,
        500000,  -418688, -81312
    };

    typedef logic [QUOT_BITS-1:0] quot_t;

endpackage

// ----- rtl/rgb_to_ypbpr_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_ypbpr_converter
// BT.601 RGB to Y'PbPr conversion, normalized by a programmable maximum.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with red, green, blue. A pixel is taken
// at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with luma, blue_diff, red_diff. A
// result is taken where out_valid is high and out_stall is low.
// Configuration: cfg_valid / cfg_ready / cfg_data writes max_sample; the port
// is always ready. Write it only while no pixel is in flight.
// Throughput: one pixel per clock unless a stalled result holds the pipeline.
// A pixel passes three arithmetic stages (products, sums, numerator) and a
// 17-stage restoring divider, one quotient bit per stage, in each of three
// lanes. The output register then holds the result.
// Reset: the pipeline empties, max_sample returns to 255, in_stall drops.
// Stall: while a result is stalled the whole pipeline holds; a one-entry
// input buffer absorbs the pixel taken in that cycle, and in_stall rises
// until the pipeline moves again.
// ----------------------------------------------------------------------------
module rgb_to_ypbpr_converter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rgbyp_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [SAMPLE_BITS-1:0]                 red,
    input  logic [SAMPLE_BITS-1:0]                 green,
    input  logic [SAMPLE_BITS-1:0]                 blue,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rgbyp_pkg::LUMA_BITS-1:0]        luma,
    output logic signed [rgbyp_pkg::DIFF_BITS-1:0] blue_diff,
    output logic signed [rgbyp_pkg::DIFF_BITS-1:0] red_diff
);

    localparam int W       = SAMPLE_BITS;
    localparam int PW      = W + 21;
    localparam int DW      = W + 20;
    localparam int NW      = W + 38;
    localparam int QB      = rgbyp_pkg::QUOT_BITS;
    localparam int NL      = rgbyp_pkg::LANES;

    logic                              en;
    logic                              in_take;
    logic                              src_valid;
    logic [W-1:0]                      src_ch [NL];

    logic [rgbyp_pkg::CFG_BITS-1:0]    max_sample_reg;
    logic [W-1:0]                      m_next;

    logic                              skid_full_reg;
    logic [W-1:0]                      skid_ch_reg [NL];

    logic                              a_valid_reg;
    logic signed [PW-1:0]              prod_reg [NL*NL];
    logic signed [PW-1:0]              prod_next [NL*NL];
    logic [DW-1:0]                     den_a_reg;

    logic                              b_valid_reg;
    logic signed [PW-1:0]              sum_reg [NL];
    logic [DW-1:0]                     den_b_reg;

    logic                              c_valid_reg;
    logic [NW-1:0]                     num_reg [NL];
    logic [NW-1:0]                     dd_reg;
    logic                              sat_reg [NL];
    logic                              neg_reg [NL];

    logic                              div_valid_reg [QB];
    rgbyp_pkg::quot_t                  quot [NL];
    logic                              qneg [NL];

    logic                              out_valid_reg;
    logic [rgbyp_pkg::LUMA_BITS-1:0]   luma_reg;
    logic [rgbyp_pkg::DIFF_BITS-1:0]   diff_reg [2];
    logic [rgbyp_pkg::LUMA_BITS-1:0]   luma_next;
    logic [rgbyp_pkg::DIFF_BITS-1:0]   diff_next [2];

    assign cfg_ready = 1'b1;
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = skid_full_reg;
    assign in_take   = in_valid && !skid_full_reg;
    assign src_valid = skid_full_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sample_reg <= rgbyp_pkg::CFG_BITS'(rgbyp_pkg::MAX_SAMPLE_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_sample_reg <= cfg_data;
        end
    end

    always_comb
    begin
        src_ch[0] = skid_full_reg ? skid_ch_reg[0] : red;
        src_ch[1] = skid_full_reg ? skid_ch_reg[1] : green;
        src_ch[2] = skid_full_reg ? skid_ch_reg[2] : blue;
        m_next    = (max_sample_reg[W-1:0] == '0) ? W'(1) : max_sample_reg[W-1:0];
        for (int l = 0; l < NL; l++)
        begin
            for (int c = 0; c < NL; c++)
            begin
                prod_next[l*NL+c] = PW'(rgbyp_pkg::COEF[l*NL+c]) * $signed(PW'(src_ch[c]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && in_take)
        begin
            skid_ch_reg[0] <= red;
            skid_ch_reg[1] <= green;
            skid_ch_reg[2] <= blue;
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < QB; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            a_valid_reg      <= src_valid;
            b_valid_reg      <= a_valid_reg;
            c_valid_reg      <= b_valid_reg;
            div_valid_reg[0] <= c_valid_reg;
            for (int i = 1; i < QB; i++)
            begin
                div_valid_reg[i] <= div_valid_reg[i-1];
            end
            out_valid_reg    <= div_valid_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NL*NL; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            den_a_reg <= DW'(m_next) * DW'(rgbyp_pkg::COEF_SCALE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NL; l++)
            begin
                sum_reg[l] <= prod_reg[l*NL] + prod_reg[l*NL+1] + prod_reg[l*NL+2];
            end
            den_b_reg <= den_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [NW-1:0] mag;
        logic [NW-1:0] num;
        logic [NW-1:0] dd;
        if (en)
        begin
            dd     = NW'(den_b_reg) << 1;
            dd_reg <= dd;
            for (int l = 0; l < NL; l++)
            begin
                mag = sum_reg[l][PW-1] ? NW'(-sum_reg[l]) : NW'(sum_reg[l]);
                num = (mag << (rgbyp_pkg::FRAC_SHIFT + 1)) + NW'(den_b_reg);
                num_reg[l] <= num;
                sat_reg[l] <= (num >= (dd << QB));
                neg_reg[l] <= sum_reg[l][PW-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NL; g++)
        begin : g_lane
            rgbyp_divider #(
                .NW (NW)
            ) u_div (
                .clk     (clk),
                .en      (en),
                .num     (num_reg[g]),
                .den     (dd_reg),
                .sat     (sat_reg[g]),
                .neg_in  (neg_reg[g]),
                .quot    (quot[g]),
                .neg_out (qneg[g])
            );
        end
    endgenerate

    // clamp
    always_comb
    begin
        logic [QB-1:0] cap;
        logic [QB-1:0] mag;
        if (qneg[0])
        begin
            luma_next = '0;
        end
        else if (quot[0] > QB'(rgbyp_pkg::LUMA_MAX))
        begin
            luma_next = rgbyp_pkg::LUMA_BITS'(rgbyp_pkg::LUMA_MAX);
        end
        else
        begin
            luma_next = rgbyp_pkg::LUMA_BITS'(quot[0]);
        end
        for (int l = 1; l < NL; l++)
        begin
            cap = qneg[l] ? QB'(rgbyp_pkg::DIFF_NEG_MAX) : QB'(rgbyp_pkg::DIFF_POS_MAX);
            mag = (quot[l] > cap) ? cap : quot[l];
            diff_next[l-1] = rgbyp_pkg::DIFF_BITS'(qneg[l] ? (QB'(0) - mag) : mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            luma_reg    <= luma_next;
            diff_reg[0] <= diff_next[0];
            diff_reg[1] <= diff_next[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign luma      = luma_reg;
    assign blue_diff = $signed(diff_reg[0]);
    assign red_diff  = $signed(diff_reg[1]);

endmodule

// ----- rtl/rgbyp_divider.sv -----
// ----------------------------------------------------------------------------
// rgbyp_divider
// Pipelined restoring divider, one quotient bit per stage, with a sign tag
// and a saturation flag that forces an all-ones quotient.
// ----------------------------------------------------------------------------
module rgbyp_divider #(
    parameter int NW = 54
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NW-1:0]        num,
    input  logic [NW-1:0]        den,
    input  logic                 sat,
    input  logic                 neg_in,
    output rgbyp_pkg::quot_t     quot,
    output logic                 neg_out
);

    localparam int QB = rgbyp_pkg::QUOT_BITS;

    logic [NW-1:0]    r_reg   [QB-1];
    logic [NW-1:0]    d_reg   [QB-1];
    rgbyp_pkg::quot_t q_reg   [QB];
    logic             neg_reg [QB];

    genvar i;
    generate
        for (i = 0; i < QB; i++)
        begin : g_stage
            logic [NW-1:0]    r_in;
            logic [NW-1:0]    d_in;
            logic [NW-1:0]    d_shift;
            rgbyp_pkg::quot_t q_in;
            logic             n_in;
            logic             fits;
            rgbyp_pkg::quot_t q_next;

            if (i == 0)
            begin : g_first
                assign r_in = sat ? '0 : num;
                assign d_in = den;
                assign q_in = sat ? '1 : '0;
                assign n_in = neg_in;
            end
            else
            begin : g_rest
                assign r_in = r_reg[i-1];
                assign d_in = d_reg[i-1];
                assign q_in = q_reg[i-1];
                assign n_in = neg_reg[i-1];
            end

            assign d_shift = d_in << (QB - 1 - i);
            assign fits    = (r_in >= d_shift);
            assign q_next  = fits ? (q_in | (QB'(1) << (QB - 1 - i))) : q_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[i]   <= q_next;
                    neg_reg[i] <= n_in;
                end
            end

            if (i < QB - 1)
            begin : g_carry
                logic [NW-1:0] r_next;

                assign r_next = fits ? (r_in - d_shift) : r_in;

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        r_reg[i] <= r_next;
                        d_reg[i] <= d_in;
                    end
                end
            end
        end
    endgenerate

    assign quot    = q_reg[QB-1];
    assign neg_out = neg_reg[QB-1];

endmodule

// ----- tb/sv/tb_rgb_to_ypbpr_converter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_ypbpr_converter
// Drives RGB pixels through the converter under several max_sample settings
// and checks every luma and color difference result against a BT.601
// predictor that rounds and saturates the same way, with random gaps on the
// pixel side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_rgb_to_ypbpr_converter;

    localparam int SAMPLE_BITS  = 16;
    localparam int LATENCY      = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam longint PPM      = 1000000;

    typedef struct packed {
        logic [rgbyp_pkg::LUMA_BITS-1:0] luma;
        logic [rgbyp_pkg::DIFF_BITS-1:0] blue_diff;
        logic [rgbyp_pkg::DIFF_BITS-1:0] red_diff;
    } ypbpr_t;

    localparam longint LUMA_WT [3] = '{299000, 587000, 114000};
    localparam longint PB_WT   [3] = '{-168736, -331264, 500000};
    localparam longint PR_WT   [3] = '{500000, -418688, -81312};

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [rgbyp_pkg::CFG_BITS-1:0]         cfg_data = '0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic [SAMPLE_BITS-1:0]                 red = '0;
    logic [SAMPLE_BITS-1:0]                 green = '0;
    logic [SAMPLE_BITS-1:0]                 blue = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic [rgbyp_pkg::LUMA_BITS-1:0]        luma;
    logic signed [rgbyp_pkg::DIFF_BITS-1:0] blue_diff;
    logic signed [rgbyp_pkg::DIFF_BITS-1:0] red_diff;

    ypbpr_t                         pending_ypbpr [$];
    logic [rgbyp_pkg::CFG_BITS-1:0] max_sample_now = 16'd255;
    bit                             tx_gaps_on = 1'b1;
    bit                             rx_stalls_on = 1'b1;
    int                             mismatch_count = 0;
    int                             cycle_count = 0;

    rgb_to_ypbpr_converter #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .luma      (luma),
        .blue_diff (blue_diff),
        .red_diff  (red_diff)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_rgb_to_ypbpr_converter failed");
            $finish;
        end
    end

    // round(sum * 65536 / den), halves away from zero
    function automatic longint scale_round(longint sum, longint den);
        longint mag;
        longint q;
        mag = (sum < 0) ? -sum : sum;
        q = (2 * mag * 65536 + den) / (2 * den);
        return (sum < 0) ? -q : q;
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic ypbpr_t convert_pixel(logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b, logic [15:0] max_s);
        longint den;
        longint ch [3];
        longint acc_y;
        longint acc_pb;
        longint acc_pr;
        ypbpr_t res;
        ch[0] = r;
        ch[1] = g;
        ch[2] = b;
        den = ((max_s == 0) ? 64'd1 : longint'(max_s)) * PPM;
        acc_y = 0;
        acc_pb = 0;
        acc_pr = 0;
        for (int i = 0; i < 3; i++)
        begin
            acc_y  += LUMA_WT[i] * ch[i];
            acc_pb += PB_WT[i] * ch[i];
            acc_pr += PR_WT[i] * ch[i];
        end
        res.luma      = rgbyp_pkg::LUMA_BITS'(
                            saturate(scale_round(acc_y, den), 0, 65536));
        res.blue_diff = rgbyp_pkg::DIFF_BITS'(
                            saturate(scale_round(acc_pb, den), -32768, 32767));
        res.red_diff  = rgbyp_pkg::DIFF_BITS'(
                            saturate(scale_round(acc_pr, den), -32768, 32767));
        return res;
    endfunction

    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        ypbpr_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ypbpr.size() == 0)
            begin
                $display("%0t: result with no pixel pending, actual %0d %0d %0d", $time,
                         luma, blue_diff, red_diff);
                mismatch_count++;
            end
            else
            begin
                want = pending_ypbpr.pop_front();
                compare_field("luma", int'(want.luma), int'(luma));
                compare_field("blue_diff", int'($signed(want.blue_diff)), int'(blue_diff));
                compare_field("red_diff", int'($signed(want.red_diff)), int'(red_diff));
            end
        end
        out_stall <= rx_stalls_on && ($urandom_range(99) < 38);
    end

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        int gap;
        gap = 0;
        while (tx_gaps_on && $urandom_range(99) < 38)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_ypbpr.push_back(convert_pixel(r, g, b, max_sample_now));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_ypbpr.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_max_sample(logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_sample_now = value;
    endtask

    task automatic send_random(int count, bit pause_midway);
        int top;
        logic [15:0] ch [3];
        top = (max_sample_now == 0) ? 1 : int'(max_sample_now);
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
                drain_results();
            for (int i = 0; i < 3; i++)
                ch[i] = ($urandom_range(99) < 10) ? 16'($urandom_range(65535, 0))
                                                  : 16'($urandom_range(top, 0));
            send_pixel(ch[0], ch[1], ch[2]);
        end
    endtask

    task automatic test_reset_default();
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd255, 16'd255, 16'd255);
        send_pixel(16'd255, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd255, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd255);
        send_pixel(16'd255, 16'd255, 16'd0);
        send_pixel(16'd128, 16'd64, 16'd200);
        send_pixel(16'hFFFF, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_zero_max_sample();
        write_max_sample(16'd0);
        send_pixel(16'd1, 16'd1, 16'd1);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd1);
        send_pixel(16'd0, 16'd1, 16'd0);
        send_random(60, 1'b0);
    endtask

    task automatic test_full_scale_max();
        write_max_sample(16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'd0, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h7FFF);
        send_pixel(16'd1, 16'd0, 16'd1);
        send_random(200, 1'b0);
    endtask

    task automatic test_random_settings();
        write_max_sample(16'd255);
        send_random(300, 1'b1);
        write_max_sample(16'd1);
        send_random(80, 1'b0);
        write_max_sample(16'd1023);
        send_random(200, 1'b0);
        write_max_sample(16'($urandom_range(65535, 2)));
        send_random(250, 1'b0);
    endtask

    task automatic test_back_to_back();
        write_max_sample(16'd4095);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        send_random(200, 1'b0);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        send_random(60, 1'b0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_zero_max_sample();
        test_full_scale_max();
        test_random_settings();
        test_back_to_back();
        drain_results();
        if (mismatch_count == 0 && pending_ypbpr.size() == 0)
            $display("tb_rgb_to_ypbpr_converter passed");
        else
            $display("tb_rgb_to_ypbpr_converter failed");
        $finish;
    end

endmodule

// ----- rgb_to_ypbpr_converter.f -----
rtl/rgbyp_pkg.sv
rtl/rgbyp_divider.sv
rtl/rgb_to_ypbpr_converter.sv
tb/sv/tb_rgb_to_ypbpr_converter.sv
